FILE: hdl/lcg48_random_generator_defines.svh
// Assertion macros shared by the generator modules.
// Depends on clk and rst_n being visible in the module that uses them.
`ifndef LCG48_RANDOM_GENERATOR_DEFINES_SVH
`define LCG48_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LCG48_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LCG48_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/lcg48_pkg.sv
// Shared types and constants of the 48-bit LCG generator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package lcg48_pkg;

    localparam int STATE_W = 48;
    localparam int INT_W   = 32;
    localparam int BITS_W  = 31;
    localparam int FRAC_W  = 53;
    localparam int HI_W    = 26;
    localparam int LO_W    = 27;
    localparam int CHUNK_W = 16;
    localparam int MULT_W  = 35;

    localparam logic [MULT_W-1:0]  LCG_MULT     = 35'h5DEECE66D;
    localparam logic [STATE_W-1:0] LCG_ADD      = 48'hB;
    localparam logic [STATE_W-1:0] SEED_SCRAMBLE = 48'h0005DEECE66D;

    // Three 16-bit chunks of the state, one per multiply step
    localparam logic [1:0] MUL_LAST_STEP = 2'd2;
    // One quotient bit per divide step
    localparam logic [4:0] DIV_LAST_STEP = 5'd30;

    typedef enum logic [1:0] {
        ACT_PLAIN    = 2'd0,
        ACT_BOUNDED  = 2'd1,
        ACT_FRACTION = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MUL2,
        S_DIV,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic cfg_load;
        logic load_req;
        logic mul_start;
        logic cap_hi;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    pow2;
        logic    mul_done;
        logic    div_done;
        logic    reject;
        logic    out_free;
    } dp_status_t;

endpackage

FILE: hdl/lcg48_random_generator.sv
// 48-bit linear congruential generator, multiplier 0x5DEECE66D, increment 0xB.
// Channels: a request channel (action, bound) with in_valid/in_ready, a result
// channel (int_value, fraction) with out_valid/out_ready, and a seed write
// channel (seed_value) with cfg_valid/cfg_ready. Each request beat gives one
// result beat. Seed beats are taken only between requests.
// The state advance is a 16-bit by 35-bit multiplier used over three steps; the
// modulo is a restoring divider giving one bit a cycle, and it sets the pace of
// bounded draws. One request is in work at a time; the next is taken once the
// result sits in the output register.
// Reset loads the state with 0x5DEECE66D and empties the output register.
// While the receiver stalls the result beat is held unchanged; a finished
// following request waits until that beat is taken.
// Depends on lcg48_pkg, lcg48_ctrl and lcg48_datapath.
`timescale 1ns / 1ps

module lcg48_random_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcg48_pkg::STATE_W-1:0]        seed_value,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           action,
    input  logic [lcg48_pkg::BITS_W-1:0]         bound,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lcg48_pkg::INT_W-1:0]   int_value,
    output logic [lcg48_pkg::FRAC_W-1:0]         fraction
);
    import lcg48_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Sequencer
    lcg48_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic and result register
    lcg48_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .seed_value (seed_value),
        .action     (action),
        .bound      (bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .int_value  (int_value),
        .fraction   (fraction)
    );

endmodule

FILE: hdl/lcg48_datapath.sv
// Datapath of the LCG generator: state register, chunked constant multiplier,
// serial restoring divider, rejection test and output register. Uses lcg48_pkg.
`timescale 1ns / 1ps
`include "lcg48_random_generator_defines.svh"

module lcg48_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lcg48_pkg::ctrl_cmd_t                 cmd,
    output lcg48_pkg::dp_status_t                sts,
    input  logic [lcg48_pkg::STATE_W-1:0]        seed_value,
    input  logic [1:0]                           action,
    input  logic [lcg48_pkg::BITS_W-1:0]         bound,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lcg48_pkg::INT_W-1:0]   int_value,
    output logic [lcg48_pkg::FRAC_W-1:0]         fraction
);
    import lcg48_pkg::*;

    logic [STATE_W-1:0] state_reg;
    action_t            act_reg;
    logic [BITS_W-1:0]  bound_reg;
    logic [HI_W-1:0]    hi_reg;

    logic [STATE_W-1:0] acc_reg;
    logic [1:0]         mul_cnt_reg;
    logic               mul_busy_reg;
    logic               mul_done_reg;
    logic [CHUNK_W-1:0] chunk;
    logic [CHUNK_W+MULT_W-1:0] chunk_prod;
    logic [STATE_W-1:0] term;
    logic [STATE_W-1:0] acc_next;

    logic [BITS_W-1:0]  dvd_reg;
    logic [BITS_W-1:0]  bits_reg;
    logic [BITS_W-1:0]  rem_reg;
    logic [4:0]         div_cnt_reg;
    logic               div_busy_reg;
    logic               div_done_reg;
    logic [BITS_W:0]    shifted;
    logic [BITS_W+1:0]  diff;
    logic [BITS_W+1:0]  check_sum;

    logic               out_valid_reg;
    logic [INT_W-1:0]   int_next;
    logic [FRAC_W-1:0]  frac_next;
    logic [INT_W-1:0]   int_value_reg;
    logic [FRAC_W-1:0]  fraction_reg;
    logic [2*BITS_W-1:0] pow2_prod;
    logic [BITS_W-1:0]  bound_m1;

    // Select the state chunk and weight its partial product
    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:    chunk = state_reg[CHUNK_W-1:0];
            2'd1:    chunk = state_reg[2*CHUNK_W-1:CHUNK_W];
            default: chunk = state_reg[3*CHUNK_W-1:2*CHUNK_W];
        endcase
        chunk_prod = (CHUNK_W+MULT_W)'(chunk) * (CHUNK_W+MULT_W)'(LCG_MULT);
        case (mul_cnt_reg)
            2'd0:    term = chunk_prod[STATE_W-1:0];
            2'd1:    term = {chunk_prod[STATE_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            default: term = {chunk_prod[STATE_W-2*CHUNK_W-1:0], {2*CHUNK_W{1'b0}}};
        endcase
        acc_next = acc_reg + term;
    end

    // Advance the generator state over three multiply steps; reload on a seed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SEED_SCRAMBLE;
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= 2'd0;
            acc_reg      <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (cmd.cfg_load)
            begin
                state_reg <= seed_value ^ SEED_SCRAMBLE;
            end
            if (cmd.mul_start)
            begin
                acc_reg      <= LCG_ADD;
                mul_cnt_reg  <= 2'd0;
                mul_busy_reg <= 1'b1;
            end
            else if (mul_busy_reg)
            begin
                acc_reg     <= acc_next;
                mul_cnt_reg <= mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == MUL_LAST_STEP)
                begin
                    state_reg    <= acc_next;
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the request fields and the upper fraction part
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg   <= action_t'(action);
            bound_reg <= bound;
        end
        if (cmd.cap_hi)
        begin
            hi_reg <= state_reg[STATE_W-1:STATE_W-HI_W];
        end
    end

    // One restoring divide step
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[BITS_W-1]};
        diff    = {1'b0, shifted} - {2'b00, bound_reg};
    end

    // Reduce the drawn bits modulo the bound, one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            div_cnt_reg  <= 5'd0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_cnt_reg  <= 5'd0;
                div_busy_reg <= 1'b1;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == DIV_LAST_STEP)
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg  <= state_reg[STATE_W-1:STATE_W-BITS_W];
            bits_reg <= state_reg[STATE_W-1:STATE_W-BITS_W];
            rem_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            dvd_reg <= {dvd_reg[BITS_W-2:0], 1'b0};
            rem_reg <= diff[BITS_W+1] ? shifted[BITS_W-1:0] : diff[BITS_W-1:0];
        end
    end

    // Bias test: bits - rem + bound - 1 must stay below 2^31
    always_comb
    begin
        bound_m1  = bound_reg - BITS_W'(1);
        check_sum = {2'b00, bits_reg} - {2'b00, rem_reg} + {2'b00, bound_m1};
    end

    // Form the result from the current state
    always_comb
    begin
        pow2_prod = (2*BITS_W)'(bound_reg) * (2*BITS_W)'(state_reg[STATE_W-1:STATE_W-BITS_W]);
        int_next  = '0;
        frac_next = '0;
        case (act_reg)
            ACT_PLAIN:
            begin
                int_next = state_reg[STATE_W-1:STATE_W-INT_W];
            end
            ACT_BOUNDED:
            begin
                if (sts.pow2)
                begin
                    int_next = {1'b0, pow2_prod[2*BITS_W-1:BITS_W]};
                end
                else
                begin
                    int_next = {1'b0, rem_reg};
                end
            end
            ACT_FRACTION:
            begin
                frac_next = {hi_reg, state_reg[STATE_W-1:STATE_W-LO_W]};
            end
            default:
            begin
                int_next  = '0;
                frac_next = '0;
            end
        endcase
    end

    // Output register: load a finished result, drop it once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            int_value_reg <= int_next;
            fraction_reg  <= frac_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign int_value = int_value_reg;
    assign fraction  = fraction_reg;

    // Status toward the controller
    assign sts.action   = act_reg;
    assign sts.pow2     = ((bound_reg & bound_m1) == '0);
    assign sts.mul_done = mul_done_reg;
    assign sts.div_done = div_done_reg;
    assign sts.reject   = check_sum[BITS_W+1] | check_sum[BITS_W];
    assign sts.out_free = !out_valid_reg || out_ready;

    `LCG48_ASSERT_NOW(a_rem_below_bound, div_done_reg, rem_reg < bound_reg, "remainder not below bound")
    `LCG48_ASSERT_NOW(a_units_exclusive, mul_busy_reg, !div_busy_reg, "multiplier and divider both busy")

endmodule

FILE: hdl/lcg48_ctrl.sv
// Controller of the LCG generator: sequences multiply, divide, redraw and output.
// Uses lcg48_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "lcg48_random_generator_defines.svh"

module lcg48_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             action,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  lcg48_pkg::dp_status_t  sts,
    output lcg48_pkg::ctrl_cmd_t   cmd
);
    import lcg48_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!cfg_valid && in_valid)
                begin
                    state_next = (action_t'(action) == ACT_NONE) ? S_FINISH : S_MUL;
                end
            end
            S_MUL:
            begin
                if (sts.mul_done)
                begin
                    case (sts.action)
                        ACT_FRACTION: state_next = S_MUL2;
                        ACT_BOUNDED:  state_next = sts.pow2 ? S_FINISH : S_DIV;
                        default:      state_next = S_FINISH;
                    endcase
                end
            end
            S_MUL2:
            begin
                if (sts.mul_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = sts.reject ? S_MUL : S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        cfg_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cfg_ready     = 1'b1;
                in_ready      = !cfg_valid;
                cmd.cfg_load  = cfg_valid;
                cmd.load_req  = in_valid && !cfg_valid;
                cmd.mul_start = in_valid && !cfg_valid && (action_t'(action) != ACT_NONE);
            end
            S_MUL:
            begin
                if (sts.mul_done)
                begin
                    if (sts.action == ACT_FRACTION)
                    begin
                        cmd.cap_hi    = 1'b1;
                        cmd.mul_start = 1'b1;
                    end
                    else if (sts.action == ACT_BOUNDED && !sts.pow2)
                    begin
                        cmd.div_start = 1'b1;
                    end
                end
            end
            S_MUL2:
            begin
                cmd = '0;
            end
            S_DIV:
            begin
                cmd.mul_start = sts.div_done && sts.reject;
            end
            S_FINISH:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `LCG48_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a held beat")
    `LCG48_ASSERT_NOW(a_one_unit_start, cmd.mul_start, !cmd.div_start, "multiply and divide started together")
    `LCG48_ASSERT_NEXT(a_div_holds, (state_reg == S_DIV) && !sts.div_done, state_reg == S_DIV, "left divide before it finished")
    `LCG48_ASSERT_NEXT(a_redraw_starts_mul, (state_reg == S_DIV) && sts.div_done && sts.reject, state_reg == S_MUL, "redraw did not return to multiply")

endmodule

FILE: tb/lcg48_draw_checker.sv
// Scoreboard for the 48-bit LCG generator: follows the seed, request and result channels.
// Predicts each draw from its own copy of the generator state and compares every result beat.
// Depends on lcg48_pkg for widths, constants and the action codes.
`timescale 1ns / 1ps

module lcg48_draw_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [lcg48_pkg::STATE_W-1:0]        seed_value,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [1:0]                           action,
    input  logic [lcg48_pkg::BITS_W-1:0]         bound,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [lcg48_pkg::INT_W-1:0]   int_value,
    input  logic [lcg48_pkg::FRAC_W-1:0]         fraction,
    output int                                   mismatches,
    output int                                   results_seen,
    output int                                   pending
);
    import lcg48_pkg::*;

    typedef struct packed {
        logic [INT_W-1:0]  int_value;
        logic [FRAC_W-1:0] fraction;
    } draw_result_t;

    logic [STATE_W-1:0] gen_state;
    draw_result_t       due_draws[$];
    int                 miss_total;
    int                 results_checked;

    // Advance the generator once and take its top k bits
    function automatic logic [31:0] next_bits(input int k);
        gen_state = gen_state * LCG_MULT + LCG_ADD;
        return 32'(gen_state >> (STATE_W - k));
    endfunction

    // Value in [0, lim); redraw while the 32-bit overflow test flags bias
    function automatic logic [31:0] bounded_value(input logic [BITS_W-1:0] lim);
        logic [63:0] bits;
        logic [63:0] rem;
        logic [63:0] prod;
        // a zero bound takes the power-of-two path and yields zero
        if ((lim & (lim - 1'b1)) == '0) begin
            bits = 64'(next_bits(BITS_W));
            prod = bits * 64'(lim);
            return 32'(prod >> BITS_W);
        end
        do begin
            bits = 64'(next_bits(BITS_W));
            rem  = bits % 64'(lim);
        end while (bits - rem + 64'(lim) - 64'd1 >= 64'h8000_0000);
        return 32'(rem);
    endfunction

    function automatic draw_result_t predict_draw(input logic [1:0] act,
                                                  input logic [BITS_W-1:0] lim);
        draw_result_t res;
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
        res = '0;
        case (action_t'(act))
            ACT_PLAIN:   res.int_value = next_bits(INT_W);
            ACT_BOUNDED: res.int_value = bounded_value(lim);
            ACT_FRACTION:
            begin
                hi = HI_W'(next_bits(HI_W));
                lo = LO_W'(next_bits(LO_W));
                res.fraction = {hi, lo};
            end
            // unknown action leaves the state alone and answers zero
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: draw %0d %s: got 0x%0h, want 0x%0h",
                 $time, results_checked, what, got, want);
        miss_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t want;
        if (!rst_n)
        begin
            // state resets as if seeded with zero
            gen_state       = STATE_W'(LCG_MULT);
            due_draws.delete();
            miss_total      = 0;
            results_checked = 0;
            mismatches   <= 0;
            results_seen <= 0;
            pending      <= 0;
        end
        else
        begin
            // seed beat: reload the state with the scrambled seed
            if (cfg_valid && cfg_ready)
                gen_state = seed_value ^ STATE_W'(LCG_MULT);

            // result beat: compare against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (due_draws.size() == 0)
                    report_mismatch("beat with nothing due", 64'(int_value), '0);
                else
                begin
                    want = due_draws.pop_front();
                    if (int_value !== want.int_value)
                        report_mismatch("int_value", 64'(int_value), 64'(want.int_value));
                    if (fraction !== want.fraction)
                        report_mismatch("fraction", 64'(fraction), 64'(want.fraction));
                end
                results_checked++;
            end

            // request beat: predict its result
            if (in_valid && in_ready)
                due_draws.push_back(predict_draw(action, bound));

            mismatches   <= miss_total;
            results_seen <= results_checked;
            pending      <= due_draws.size();
        end
    end

endmodule

FILE: tb/tb_lcg48_random_generator.sv
// Testbench top for lcg48_random_generator: drives seeds and draw requests, stalls results.
// Directed corner draws, then random phases under several seeds; verdict from lcg48_draw_checker.
// Depends on lcg48_pkg, the generator RTL and tb/lcg48_draw_checker.sv.
`timescale 1ns / 1ps

module tb_lcg48_random_generator;

    import lcg48_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int END_DRAIN   = 80;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [STATE_W-1:0]        seed_value = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [1:0]                action = ACT_PLAIN;
    logic [BITS_W-1:0]         bound = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [INT_W-1:0]   int_value;
    logic [FRAC_W-1:0]         fraction;

    int mismatches;
    int results_seen;
    int pending;
    int requests_sent = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    bit calm = 1'b0;

    lcg48_random_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .seed_value (seed_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .bound      (bound),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .int_value  (int_value),
        .fraction   (fraction)
    );

    lcg48_draw_checker u_draw_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .seed_value   (seed_value),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .bound        (bound),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .int_value    (int_value),
        .fraction     (fraction),
        .mismatches   (mismatches),
        .results_seen (results_seen),
        .pending      (pending)
    );

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lcg48_random_generator: mismatch");
            $finish;
        end
    end

    // Idle percentage for a stretch: none, light or heavy
    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 12;
            default: return 45;
        endcase
    endfunction

    // Result side: stall in random bursts
    initial
    begin : result_sink
        int stall_pct;
        int held;
        stall_pct = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0)
                stall_pct = pick_rate();
            if (calm)
            begin
                held = 0;
                out_ready <= 1'b1;
            end
            else if (held > 0)
            begin
                held--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                held = $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Present one request beat, after an optional idle burst, and hold it until taken
    task automatic send_request(input action_t act, input logic [BITS_W-1:0] lim);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        bound    <= lim;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    // Hold off until every issued request has produced its result beat
    task automatic drain_results();
        in_valid <= 1'b0;
        while (results_seen != requests_sent) @(posedge clk);
    endtask

    task automatic load_seed(input logic [STATE_W-1:0] value);
        drain_results();
        cfg_valid  <= 1'b1;
        seed_value <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        action_t           act;
        logic [BITS_W-1:0] lim;
        int                pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                gap_pct = pick_rate();
            pick = $urandom_range(0, 99);
            if (pick < 25)
                act = ACT_PLAIN;
            else if (pick < 70)
                act = ACT_BOUNDED;
            else if (pick < 95)
                act = ACT_FRACTION;
            else
                act = ACT_NONE;
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    lim = BITS_W'(1) << $urandom_range(0, BITS_W - 1);
                    if ($urandom_range(0, 7) == 0)
                        lim = '0;
                end
                2, 3, 4: lim = BITS_W'($urandom_range(2, 1000));
                // just above 2^30 the redraw rate is highest
                5:       lim = 31'h4000_0000 + BITS_W'($urandom_range(1, 4096));
                default: lim = BITS_W'($urandom());
            endcase
            send_request(act, lim);
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner draws straight out of reset
        send_request(ACT_PLAIN, '0);
        send_request(ACT_PLAIN, 31'h7FFF_FFFF);
        send_request(ACT_BOUNDED, '0);
        send_request(ACT_BOUNDED, 31'd1);
        send_request(ACT_BOUNDED, 31'd2);
        send_request(ACT_BOUNDED, 31'd3);
        send_request(ACT_BOUNDED, 31'h4000_0000);
        send_request(ACT_BOUNDED, 31'h4000_0001);
        send_request(ACT_BOUNDED, 31'h7FFF_FFFF);
        send_request(ACT_BOUNDED, 31'h5555_5555);
        send_request(ACT_BOUNDED, 31'h2AAA_AAAA);
        send_request(ACT_FRACTION, 31'h7FFF_FFFF);
        send_request(ACT_FRACTION, '0);
        send_request(ACT_NONE, 31'h7FFF_FFFF);
        send_request(ACT_NONE, '0);
        send_request(ACT_PLAIN, 31'd5);
        drain_results();

        load_seed('0);
        run_random(200);

        load_seed({STATE_W{1'b1}});
        run_random(250);

        // This seed zeroes the state
        load_seed(STATE_W'(LCG_MULT));
        send_request(ACT_PLAIN, '0);
        send_request(ACT_FRACTION, '0);
        send_request(ACT_BOUNDED, 31'd7);
        run_random(250);

        load_seed(STATE_W'({$urandom(), $urandom()}));
        run_random(125);
        drain_results();
        run_random(125);

        // Final stretch without idling on either side
        load_seed(STATE_W'({$urandom(), $urandom()}));
        calm = 1'b1;
        run_random(200);

        drain_results();
        repeat (END_DRAIN) @(posedge clk);
        if (mismatches == 0 && pending == 0 && results_seen == requests_sent)
            $display("lcg48_random_generator: match");
        else
            $display("lcg48_random_generator: mismatch");
        $finish;
    end

endmodule
